// ----- hdl/tpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpsc_pkg
// Shared types and constants of the three-position step controller.
// ----------------------------------------------------------------------------
package tpsc_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int TICK_W          = 17;
	localparam int REG_IDX_W       = 3;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THRESHOLD   = 3'd0,
		REG_DEADBAND    = 3'd1,
		REG_WAIT_TICKS  = 3'd2,
		REG_PULSE_TICKS = 3'd3,
		REG_INVERSE     = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [CFG_W-1:0] threshold;
		logic [CFG_W-1:0] deadband;
		logic [CFG_W-1:0] wait_ticks;
		logic [CFG_W-1:0] pulse_ticks;
		logic             inverse_action;
	} cfg_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic              pulse_started;
		logic              up_level;
		logic              down_level;
	} ctrl_state_t;

endpackage

// ----- hdl/tpsc_step.sv -----
// ----------------------------------------------------------------------------
// tpsc_step
// Next-state logic for one control word: error, band tests, timer and levels.
// ----------------------------------------------------------------------------
module tpsc_step #(
	parameter int VALUE_WIDTH = tpsc_pkg::VALUE_WIDTH_DEF
) (
	input  tpsc_pkg::cfg_t                 cfg,
	input  tpsc_pkg::ctrl_state_t          cur,
	input  tpsc_pkg::opcode_t              opcode,
	input  logic signed [VALUE_WIDTH-1:0]  process_value,
	input  logic signed [VALUE_WIDTH-1:0]  set_point,
	input  logic                           auto_mode,
	output tpsc_pkg::ctrl_state_t          nxt
);

	localparam int ERR_W = VALUE_WIDTH + 1;
	localparam int CMP_W = (ERR_W > tpsc_pkg::CFG_W) ? ERR_W : tpsc_pkg::CFG_W;

	logic signed [ERR_W-1:0]        pv_ext;
	logic signed [ERR_W-1:0]        sp_ext;
	logic signed [ERR_W-1:0]        err;
	logic        [ERR_W-1:0]        mag;
	logic        [CMP_W-1:0]        mag_c;
	logic        [CMP_W-1:0]        dead_c;
	logic        [CMP_W-1:0]        thr_c;
	logic                           err_pos;
	logic                           err_neg;
	logic                           in_dead;
	logic                           beyond;
	logic [tpsc_pkg::TICK_W-1:0]    tick1;
	logic [tpsc_pkg::TICK_W-1:0]    wait_ext;
	logic [tpsc_pkg::TICK_W-1:0]    period_end;

	always_comb begin
		pv_ext     = ERR_W'(process_value);
		sp_ext     = ERR_W'(set_point);
		err        = cfg.inverse_action ? (pv_ext - sp_ext) : (sp_ext - pv_ext);
		err_neg    = err[ERR_W-1];
		err_pos    = !err_neg && (err != '0);
		mag        = err_neg ? ERR_W'(-err) : ERR_W'(err);
		mag_c      = CMP_W'(mag);
		dead_c     = CMP_W'(cfg.deadband);
		thr_c      = CMP_W'(cfg.threshold);
		in_dead    = mag_c < dead_c;
		beyond     = mag_c > thr_c;
		wait_ext   = tpsc_pkg::TICK_W'(cfg.wait_ticks);
		period_end = wait_ext + tpsc_pkg::TICK_W'(cfg.pulse_ticks);

		if (in_dead || beyond) begin
			tick1 = '0;
		end else if (cur.tick_count != tpsc_pkg::TICK_MAX) begin
			tick1 = cur.tick_count + tpsc_pkg::TICK_W'(1);
		end else begin
			tick1 = cur.tick_count;
		end

		nxt = cur;
		if (opcode == tpsc_pkg::OP_CLEAR) begin
			nxt = '0;
		end else if (auto_mode) begin
			nxt.tick_count = tick1;
			if (in_dead) begin
				nxt.up_level   = 1'b0;
				nxt.down_level = 1'b0;
			end else if (beyond) begin
				nxt.up_level   = err_pos;
				nxt.down_level = err_neg;
			end else if (tick1 < wait_ext) begin
				nxt.up_level   = 1'b0;
				nxt.down_level = 1'b0;
			end else begin
				if (!cur.pulse_started) begin
					nxt.up_level      = err_pos;
					nxt.down_level    = err_neg;
					nxt.pulse_started = 1'b1;
				end
				if (tick1 > period_end) begin
					nxt.tick_count    = '0;
					nxt.pulse_started = 1'b0;
				end
			end
		end
	end

endmodule

// ----- hdl/three_position_step_controller.sv -----
// ----------------------------------------------------------------------------
// three_position_step_controller
// Three-position step controller with deadband, pulse timing and inverse action.
// An accepted word is registered in the input stage, and its result word in the
// output register once the output stage is free or being taken.
// Throughput: one word per cycle unless stalled; each update is one tpsc_step pass.
// A result word held by the receiver stalls the input once the stage is full.
// Reset clears the registers, the timer, the pulse flag and both output levels.
// A write to a defined register also clears the timer and the pulse flag.
// ----------------------------------------------------------------------------
module three_position_step_controller #(
	parameter int VALUE_WIDTH = tpsc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// process_value, set_point, auto_mode, zero fill
	input  logic [((2*VALUE_WIDTH+1+7)/8)*8-1:0]    s_axis_tdata,
	// opcode
	input  logic                                    s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// drive_up, drive_down, zero fill
	output logic [7:0]                              m_axis_tdata,
	input  logic                                    cfg_we,
	input  logic [tpsc_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [tpsc_pkg::CFG_W-1:0]              cfg_data
);

	tpsc_pkg::cfg_t                cfg_q;
	tpsc_pkg::ctrl_state_t         state_q;
	tpsc_pkg::ctrl_state_t         state_nxt;
	logic                          valid_s1;
	tpsc_pkg::opcode_t             opcode_s1;
	logic signed [VALUE_WIDTH-1:0] pv_s1;
	logic signed [VALUE_WIDTH-1:0] sp_s1;
	logic                          auto_s1;
	logic                          out_valid_q;
	logic                          up_q;
	logic                          down_q;
	logic                          adv;
	logic                          cfg_hit;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, down_q, up_q};

	always_comb begin
		case (tpsc_pkg::reg_idx_t'(cfg_index))
			tpsc_pkg::REG_THRESHOLD, tpsc_pkg::REG_DEADBAND, tpsc_pkg::REG_WAIT_TICKS,
			tpsc_pkg::REG_PULSE_TICKS, tpsc_pkg::REG_INVERSE: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (tpsc_pkg::reg_idx_t'(cfg_index))
				tpsc_pkg::REG_THRESHOLD:   cfg_q.threshold      <= cfg_data;
				tpsc_pkg::REG_DEADBAND:    cfg_q.deadband       <= cfg_data;
				tpsc_pkg::REG_WAIT_TICKS:  cfg_q.wait_ticks     <= cfg_data;
				tpsc_pkg::REG_PULSE_TICKS: cfg_q.pulse_ticks    <= cfg_data;
				tpsc_pkg::REG_INVERSE:     cfg_q.inverse_action <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= tpsc_pkg::opcode_t'(s_axis_tuser);
			pv_s1     <= s_axis_tdata[VALUE_WIDTH-1:0];
			sp_s1     <= s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
			auto_s1   <= s_axis_tdata[2*VALUE_WIDTH];
		end
	end

	tpsc_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.cfg           (cfg_q),
		.cur           (state_q),
		.opcode        (opcode_s1),
		.process_value (pv_s1),
		.set_point     (sp_s1),
		.auto_mode     (auto_s1),
		.nxt           (state_nxt)
	);

	// A defined-register write restarts the pulse timing but does not clear the levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cfg_hit) begin
			state_q.tick_count    <= '0;
			state_q.pulse_started <= 1'b0;
			if (adv) begin
				state_q.up_level   <= state_nxt.up_level;
				state_q.down_level <= state_nxt.down_level;
			end
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			up_q   <= state_nxt.up_level;
			down_q <= state_nxt.down_level;
		end
	end

	a_levels_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.up_level && state_q.down_level))
		else $error("both drive levels set at once");

	a_cfg_clears_timer: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (state_q.tick_count == '0) && !state_q.pulse_started)
		else $error("register write did not restart the pulse timing");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && !cfg_hit) |=> $stable(state_q))
		else $error("controller state changed without a word or a write");

	a_result_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid && (m_axis_tdata[0] == state_q.up_level)
			&& (m_axis_tdata[1] == state_q.down_level))
		else $error("result word does not match the updated levels");

endmodule

// ----- test/three_position_step_controller_tb.sv -----
// ----------------------------------------------------------------------------
// three_position_step_controller_tb
// Drives control ticks, clear words and register writes into the step
// controller and predicts each drive_up / drive_down word from its own copy of
// the timer, the pulse flag, the output levels and the registers. Directed
// words cover field extremes, band ordering, pulse timing and writes. Random phases
// follow, with sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module three_position_step_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW          = tpsc_pkg::VALUE_WIDTH_DEF;
	localparam int DATA_W      = ((2*VW+1+7)/8)*8;
	localparam int SETTLE      = 6;
	localparam int HOLD_CYCLES = 150;
	localparam int STUCK_LIMIT = 3000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic up;
		logic down;
	} drive_t;

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [DATA_W-1:0]                  s_axis_tdata;
	logic                               s_axis_tuser;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [7:0]                         m_axis_tdata;
	logic                               cfg_we;
	logic [tpsc_pkg::REG_IDX_W-1:0]     cfg_index;
	logic [tpsc_pkg::CFG_W-1:0]         cfg_data;

	tpsc_pkg::cfg_t        model_cfg;
	tpsc_pkg::ctrl_state_t model_state;
	drive_t                expected_drive[$];
	idle_mode_t            idle_mode;
	int                    mismatches;
	int                    stuck_cycles;
	bit                    hold_go;

	three_position_step_controller #(.VALUE_WIDTH(VW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic bit sender_skips();
		int pct;
		case (idle_mode)
			IDLE_SENDER: pct = 54;
			IDLE_BOTH:   pct = 7;
			default:     pct = 0;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit receiver_stalls();
		int pct;
		case (idle_mode)
			IDLE_RECEIVER: pct = 54;
			IDLE_BOTH:     pct = 7;
			default:       pct = 0;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	// One control step of the controller, applied to the word just accepted.
	function automatic drive_t advance_controller(tpsc_pkg::opcode_t op,
			logic signed [VW-1:0] pv, logic signed [VW-1:0] sp, logic auto_on);
		logic signed [VW+1:0]        err;
		logic [VW+1:0]               mag;
		logic [tpsc_pkg::TICK_W-1:0] period_end;
		logic                        in_dead;
		logic                        beyond;
		drive_t                      d;
		if (op == tpsc_pkg::OP_CLEAR) begin
			model_state = '0;
		end else if (auto_on) begin
			err = model_cfg.inverse_action ? pv - sp : sp - pv;
			mag = (err < 0) ? -err : err;
			in_dead = mag < model_cfg.deadband;
			beyond = mag > model_cfg.threshold;
			if (in_dead || beyond)
				model_state.tick_count = '0;
			else if (model_state.tick_count < tpsc_pkg::TICK_MAX)
				model_state.tick_count = model_state.tick_count + 1'b1;
			period_end = {1'b0, model_cfg.wait_ticks} + {1'b0, model_cfg.pulse_ticks};
			if (in_dead) begin
				model_state.up_level = 1'b0;
				model_state.down_level = 1'b0;
			end else if (beyond) begin
				model_state.up_level = err > 0;
				model_state.down_level = err < 0;
			end else if (model_state.tick_count < model_cfg.wait_ticks) begin
				model_state.up_level = 1'b0;
				model_state.down_level = 1'b0;
			end else begin
				if (!model_state.pulse_started) begin
					model_state.up_level = err > 0;
					model_state.down_level = err < 0;
					model_state.pulse_started = 1'b1;
				end
				if (model_state.tick_count > period_end) begin
					model_state.tick_count = '0;
					model_state.pulse_started = 1'b0;
				end
			end
		end
		d.up = model_state.up_level;
		d.down = model_state.down_level;
		return d;
	endfunction

	task automatic send_word(tpsc_pkg::opcode_t op, logic signed [VW-1:0] pv,
			logic signed [VW-1:0] sp, logic auto_on);
		@(negedge clk);
		while (sender_skips()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(DATA_W-2*VW-1){1'b0}}, auto_on, sp, pv};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		expected_drive.push_back(advance_controller(op, pv, sp, auto_on));
	endtask

	task automatic wait_for_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [tpsc_pkg::REG_IDX_W-1:0] idx,
			logic [tpsc_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			tpsc_pkg::REG_THRESHOLD:   model_cfg.threshold = value;
			tpsc_pkg::REG_DEADBAND:    model_cfg.deadband = value;
			tpsc_pkg::REG_WAIT_TICKS:  model_cfg.wait_ticks = value;
			tpsc_pkg::REG_PULSE_TICKS: model_cfg.pulse_ticks = value;
			tpsc_pkg::REG_INVERSE:     model_cfg.inverse_action = value[0];
			default:                   ;
		endcase
		if (idx <= tpsc_pkg::REG_INVERSE) begin
			model_state.tick_count = '0;
			model_state.pulse_started = 1'b0;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [tpsc_pkg::CFG_W-1:0] thr, logic [tpsc_pkg::CFG_W-1:0] db,
			logic [tpsc_pkg::CFG_W-1:0] wait_len, logic [tpsc_pkg::CFG_W-1:0] pulse_len,
			logic inv);
		wait_for_idle();
		write_reg(tpsc_pkg::REG_THRESHOLD, thr);
		write_reg(tpsc_pkg::REG_DEADBAND, db);
		write_reg(tpsc_pkg::REG_WAIT_TICKS, wait_len);
		write_reg(tpsc_pkg::REG_PULSE_TICKS, pulse_len);
		write_reg(tpsc_pkg::REG_INVERSE, {15'($urandom), inv});
	endtask

	// Mostly ticks whose error lies around the proportional band, plus noise.
	task automatic send_random_word();
		int pick;
		int lo;
		int hi;
		int mag;
		int sp_i;
		pick = $urandom_range(99);
		if (pick < 6) begin
			send_word(tpsc_pkg::OP_CLEAR, VW'($urandom), VW'($urandom),
					1'($urandom_range(1)));
		end else if (pick < 14) begin
			send_word(tpsc_pkg::OP_TICK, VW'($urandom), VW'($urandom), 1'b0);
		end else if (pick < 24) begin
			send_word(tpsc_pkg::OP_TICK, VW'($urandom), VW'($urandom), 1'b1);
		end else begin
			hi = int'(model_cfg.threshold) + 3;
			if (hi > 12000)
				hi = 12000;
			lo = int'(model_cfg.deadband) - 3;
			if (lo < 0)
				lo = 0;
			if (lo > hi)
				lo = hi;
			mag = $urandom_range(hi, lo);
			if ($urandom_range(1))
				mag = -mag;
			sp_i = int'($urandom_range(40000)) - 20000;
			send_word(tpsc_pkg::OP_TICK, VW'(sp_i - mag), VW'(sp_i), 1'b1);
		end
	endtask

	task automatic test_field_extremes();
		idle_mode = IDLE_NONE;
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(0), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(-32768), VW'(32767), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(32767), VW'(-32768), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(-32768), VW'(32767), 1'b0);
		send_word(tpsc_pkg::OP_CLEAR, VW'(32767), VW'(-32768), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(100), VW'(0), 1'b1);
		send_word(tpsc_pkg::OP_CLEAR, VW'(0), VW'(0), 1'b0);
		send_word(tpsc_pkg::OP_TICK, VW'(-1), VW'(-1), 1'b1);
	endtask

	task automatic test_band_order();
		set_config(16'd50, 16'd100, 16'd0, 16'd0, 1'b0);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(75), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(200), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(200), VW'(0), 1'b1);
		wait_for_idle();
		write_reg(tpsc_pkg::REG_INVERSE, 16'h0001);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(200), 1'b1);
	endtask

	task automatic test_pulse_timing();
		set_config(16'd1000, 16'd10, 16'd2, 16'd1, 1'b0);
		repeat (4) send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(500), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(5000), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(500), 1'b1);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(0), 1'b1);
		repeat (3) send_word(tpsc_pkg::OP_TICK, VW'(500), VW'(0), 1'b1);
	endtask

	task automatic test_register_writes();
		wait_for_idle();
		write_reg(tpsc_pkg::REG_WAIT_TICKS, 16'd3);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(500), 1'b0);
		send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(500), 1'b1);
		wait_for_idle();
		write_reg(3'($urandom_range(7, 5)), 16'($urandom));
		repeat (3) send_word(tpsc_pkg::OP_TICK, VW'(0), VW'(500), 1'b1);
	endtask

	task automatic test_random_regulation();
		for (int p = 0; p < 8; p++) begin
			case (p)
				2: set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
				5: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						1'($urandom));
				6: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
				default: begin
					set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
					write_reg(tpsc_pkg::REG_DEADBAND, 16'($urandom_range(60)));
					write_reg(tpsc_pkg::REG_THRESHOLD,
							16'(model_cfg.deadband + $urandom_range(300)));
					write_reg(tpsc_pkg::REG_WAIT_TICKS, 16'($urandom_range(5)));
					write_reg(tpsc_pkg::REG_PULSE_TICKS, 16'($urandom_range(5)));
					write_reg(tpsc_pkg::REG_INVERSE, 16'($urandom));
					if ($urandom_range(1))
						write_reg(3'($urandom_range(7, 5)), 16'($urandom));
				end
			endcase
			idle_mode = idle_mode_t'(p % 4);
			repeat (48) send_random_word();
		end
	endtask

	task automatic test_output_backpressure();
		set_config(16'd400, 16'd20, 16'd1, 16'd2, 1'b0);
		idle_mode = IDLE_NONE;
		@(posedge clk);
		hold_go = 1'b1;
		repeat (24) send_random_word();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		model_cfg = '0;
		model_state = '0;
		idle_mode = IDLE_NONE;
		mismatches = 0;
		hold_go = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_field_extremes();
		test_band_order();
		test_pulse_timing();
		test_register_writes();
		test_random_regulation();
		test_output_backpressure();
		wait_for_idle();
		if (mismatches == 0)
			$display("three_position_step_controller_tb OK");
		else
			$display("three_position_step_controller_tb NOT OK");
		$finish;
	end

	// The receiver holds off in one long stretch when asked, else stalls at random.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= !receiver_stalls();
		end
	end

	always @(posedge clk) begin : check_drive
		drive_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_drive.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual up %b down %b",
						$time, m_axis_tdata[0], m_axis_tdata[1]);
				mismatches++;
			end else begin
				want = expected_drive.pop_front();
				if (m_axis_tdata[0] !== want.up) begin
					$display("%0t: drive_up expected %b actual %b",
							$time, want.up, m_axis_tdata[0]);
					mismatches++;
				end
				if (m_axis_tdata[1] !== want.down) begin
					$display("%0t: drive_down expected %b actual %b",
							$time, want.down, m_axis_tdata[1]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			stuck_cycles <= 0;
		else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we)
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("three_position_step_controller_tb NOT OK");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

endmodule

// ----- sim.f -----
hdl/tpsc_pkg.sv
hdl/tpsc_step.sv
hdl/three_position_step_controller.sv
test/three_position_step_controller_tb.sv
